[rtl/delta_list_task_timer_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the delta-list timer queue.
// Each macro compiles away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TASK_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TASK_TIMER_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is high.
`define DLTQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define DLTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DLTQ_ASSERT(lbl, clk, rst, prop, msg)
`define DLTQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/dltq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and fixed constants shared by the delta-list timer queue modules.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int TASK_W    = 8;
  localparam int TICKS_W   = 16;
  localparam int MS_W      = 20;
  localparam int CMD_W     = 2;
  localparam int CNT_OUT_W = 5;
  localparam int OP_W      = 2;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd3;

  // Operations broadcast to the cell row.
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TASK_W-1:0] task_id;
    logic [MS_W-1:0]   delay_ms;
    logic [MS_W-1:0]   period_ms;
  } dltq_req_t;

  typedef struct packed {
    logic                 fired;
    logic [TASK_W-1:0]    fired_task;
    logic                 status;
    logic [CNT_OUT_W-1:0] task_count;
  } dltq_rsp_t;

  typedef struct packed {
    logic [TASK_W-1:0]  tid;
    logic [TICKS_W-1:0] delta;
    logic [TICKS_W-1:0] period;
  } dltq_entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    dltq_entry_t     ins;
  } dltq_ctl_t;

  // Where a cell sits relative to the operation pointer.
  typedef struct packed {
    logic at;
    logic above;
    logic succ;
  } dltq_cell_pos_t;

endpackage

[rtl/delta_list_task_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_task_timer_queue
// Time-ordered task queue kept as a delta list in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (add, tick, dispatch, delete) on a
//   valid/ready channel; rsp returns exactly one result item per command
//   with the fired flag, the fired task id, the add status and the count.
//   The queue lives in MAX_TASKS cells that shift by one slot on insert and
//   remove. A sequencer walks a pointer along the row, one cell per cycle,
//   to find the insert place or the entries to delete.
//   An add scales milliseconds to ticks with a registered multiply, walks
//   past the entries that expire no later than it, then inserts; a delete
//   walks the live entries and removes each match, and a periodic dispatch
//   removes the head and re-queues it as an add. Tick acts on the head.
//   One item is worked on at a time; req_ready is high only when idle.
//   The result sits in an output register, so a new item is accepted while
//   it waits; a finished item holds in place while rsp is stalled.
//   Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module delta_list_task_timer_queue #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_MS   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  dltq_pkg::dltq_req_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output dltq_pkg::dltq_rsp_t  rsp
);
  import dltq_pkg::*;
  `include "delta_list_task_timer_queue_assert.svh"

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = $clog2(MAX_TASKS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCALE  = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_DISP   = 3'd3;
  localparam logic [2:0] S_SEEK   = 3'd4;
  localparam logic [2:0] S_DEL    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [TASK_W-1:0]   cur_id, cur_id_next;
  logic [TICKS_W-1:0]  acc_delta, acc_delta_next;
  logic [TICKS_W-1:0]  acc_period, acc_period_next;
  logic                fired, fired_next;
  logic [TASK_W-1:0]   fired_task, fired_task_next;
  logic                status, status_next;
  logic                rsp_load;

  logic [TICKS_W-1:0]  delay_ticks;
  logic [TICKS_W-1:0]  period_ticks;
  logic                accept;

  dltq_ctl_t           ctl;
  dltq_entry_t         cell_q [MAX_TASKS];
  dltq_cell_pos_t      cell_pos [MAX_TASKS];
  dltq_entry_t         sel;
  logic                ptr_live;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign sel       = cell_q[ptr[IDX_W-1:0]];
  assign ptr_live  = (ptr < count);

  dltq_scale #(.TICK_MS(TICK_MS)) u_scale_delay (
    .clk   (clk),
    .load  (accept),
    .ms    (req.delay_ms),
    .ticks (delay_ticks)
  );

  dltq_scale #(.TICK_MS(TICK_MS)) u_scale_period (
    .clk   (clk),
    .load  (accept),
    .ms    (req.period_ms),
    .ticks (period_ticks)
  );

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    dltq_entry_t left_q;
    dltq_entry_t right_q;

    if (i == 0) begin : g_first
      assign left_q = cell_q[i];
    end else begin : g_inner_l
      assign left_q = cell_q[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_inner_r
      assign right_q = cell_q[i+1];
    end

    assign cell_pos[i].at    = (ptr == CNT_W'(i));
    assign cell_pos[i].above = (ptr < CNT_W'(i));
    assign cell_pos[i].succ  = (({1'b0, ptr} + 1'b1) == (CNT_W + 1)'(i));

    dltq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (cell_pos[i]),
      .left  (left_q),
      .right (right_q),
      .entry (cell_q[i])
    );
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    cur_id_next     = cur_id;
    acc_delta_next  = acc_delta;
    acc_period_next = acc_period;
    fired_next      = fired;
    fired_task_next = fired_task;
    status_next     = status;
    rsp_load        = 1'b0;
    ctl.op          = OP_HOLD;
    ctl.ins.tid     = cur_id;
    ctl.ins.delta   = acc_delta;
    ctl.ins.period  = acc_period;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ptr_next        = '0;
          cur_id_next     = req.task_id;
          fired_next      = 1'b0;
          fired_task_next = '0;
          status_next     = 1'b0;
          case (req.command)
            CMD_ADD:      state_next = S_SCALE;
            CMD_TICK:     state_next = S_TICK;
            CMD_DISPATCH: state_next = S_DISP;
            CMD_DELETE:   state_next = S_DEL;
            default:      state_next = S_DEL;
          endcase
        end
      end
      S_SCALE: begin
        if (count >= CNT_W'(MAX_TASKS)) begin
          status_next = 1'b1;
          state_next  = S_FINISH;
        end else begin
          acc_delta_next  = delay_ticks;
          acc_period_next = period_ticks;
          state_next      = S_SEEK;
        end
      end
      S_TICK: begin
        if (count != '0) begin
          ctl.op = OP_TICK;
        end
        state_next = S_FINISH;
      end
      S_DISP: begin
        if ((count != '0) && (cell_q[0].delta == '0)) begin
          fired_next      = 1'b1;
          fired_task_next = cell_q[0].tid;
          ctl.op          = OP_REMOVE;
          count_next      = count - 1'b1;
          if (cell_q[0].period != '0) begin
            // A periodic task goes back in as a fresh add of its period.
            cur_id_next     = cell_q[0].tid;
            acc_delta_next  = cell_q[0].period;
            acc_period_next = cell_q[0].period;
            state_next      = S_SEEK;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SEEK: begin
        // Pass every entry that expires no later than the new one.
        if (ptr_live && (acc_delta >= sel.delta)) begin
          acc_delta_next = acc_delta - sel.delta;
          ptr_next       = ptr + 1'b1;
        end else begin
          ctl.op     = OP_INSERT;
          count_next = count + 1'b1;
          state_next = S_FINISH;
        end
      end
      S_DEL: begin
        if (ptr_live) begin
          if (sel.tid == cur_id) begin
            ctl.op     = OP_REMOVE;
            count_next = count - 1'b1;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    cur_id     <= cur_id_next;
    acc_delta  <= acc_delta_next;
    acc_period <= acc_period_next;
    fired      <= fired_next;
    fired_task <= fired_task_next;
    status     <= status_next;
    if (rsp_load) begin
      rsp.fired      <= fired;
      rsp.fired_task <= fired_task;
      rsp.status     <= status;
      rsp.task_count <= CNT_OUT_W'(count);
    end
  end

  `DLTQ_ASSERT(a_busy_after_accept, clk, rst, (req_valid && req_ready) |=> !req_ready, "item accepted while busy")
  `DLTQ_ASSERT(a_insert_has_room, clk, rst, (ctl.op == OP_INSERT) |-> (count < CNT_W'(MAX_TASKS)), "insert into a full queue")
  `DLTQ_ASSERT(a_remove_in_range, clk, rst, (ctl.op == OP_REMOVE) |-> (ptr < count), "remove beyond the queue tail")
  `DLTQ_ASSERT(a_fire_not_reject, clk, rst, rsp_valid |-> !(rsp.fired && rsp.status), "fired and rejected together")

endmodule

[rtl/dltq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_cell
// One slot of the delta list; shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module dltq_cell (
  input  logic                       clk,
  input  dltq_pkg::dltq_ctl_t        ctl,
  input  dltq_pkg::dltq_cell_pos_t   pos,
  input  dltq_pkg::dltq_entry_t      left,
  input  dltq_pkg::dltq_entry_t      right,
  output dltq_pkg::dltq_entry_t      entry
);
  import dltq_pkg::*;

  dltq_entry_t        entry_next;
  logic [TICKS_W:0]   fold_sum;

  // A removed entry hands its delay to the one that slides into its place.
  assign fold_sum = {1'b0, right.delta} + {1'b0, entry.delta};

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      OP_TICK: begin
        if (pos.at && (entry.delta != '0)) begin
          entry_next.delta = entry.delta - 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos.at) begin
          entry_next = ctl.ins;
        end else if (pos.above) begin
          entry_next = left;
          if (pos.succ) begin
            entry_next.delta = left.delta - ctl.ins.delta;
          end
        end
      end
      OP_REMOVE: begin
        if (pos.at) begin
          entry_next = right;
          entry_next.delta = fold_sum[TICKS_W] ? '1 : fold_sum[TICKS_W-1:0];
        end else if (pos.above) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[rtl/dltq_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_scale
// Converts milliseconds to ticks by reciprocal multiply, saturating at 16 bits.
// ----------------------------------------------------------------------------
module dltq_scale #(
  parameter int TICK_MS = 10
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [dltq_pkg::MS_W-1:0]     ms,
  output logic [dltq_pkg::TICKS_W-1:0]  ticks
);
  import dltq_pkg::*;

  // With this shift the rounded-up reciprocal gives the exact floor for every
  // input below 2**MS_W, and the reciprocal fits in MS_W + 2 bits.
  localparam int TICK_SHIFT = MS_W + $clog2(TICK_MS);
  localparam int RECIP_W    = MS_W + 2;
  localparam int PROD_W     = MS_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << TICK_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [RECIP_W-1:0] TICK_RECIP = RECIP_W'(RECIP_L);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(ms) * PROD_W'(TICK_RECIP);
    end
  end

  assign quot  = prod >> TICK_SHIFT;
  assign ticks = (|quot[PROD_W-1:TICKS_W]) ? '1 : quot[TICKS_W-1:0];

endmodule

[tb/tb_delta_list_task_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_list_task_timer_queue
// Self-checking bench for the delta-list timer queue. A short table of
// commands covers the empty queue, field extremes, scaling and saturation,
// re-queue of periodic tasks, the full queue and deletes of repeated ids.
// A random run of about 500 commands follows. Each result is compared with a
// literal value where the table gives one, else with a bench copy of the queue.
// ----------------------------------------------------------------------------
module tb_delta_list_task_timer_queue;
  import dltq_pkg::*;

  localparam int MAX_TASKS  = 16;
  localparam int TICK_MS    = 10;
  localparam int RAND_ITEMS = 500;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    dltq_req_t req;
    int        reps;
    int        step_ms;
    bit        lit;
    dltq_rsp_t want;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  dltq_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  dltq_rsp_t rsp;

  // Bench copy of the timer queue.
  logic [TASK_W-1:0]  q_task[MAX_TASKS];
  logic [TICKS_W-1:0] q_delta[MAX_TASKS];
  logic [TICKS_W-1:0] q_period[MAX_TASKS];
  int unsigned        q_len = 0;

  dltq_rsp_t awaited_rsp[$];
  dir_row_t  dir_rows[$];
  int        errors = 0;
  bit        quiet = 1'b0;
  int        rsp_hold = 0;

  delta_list_task_timer_queue #(
    .MAX_TASKS(MAX_TASKS),
    .TICK_MS  (TICK_MS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [TICKS_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    int unsigned q;
    q = ms;
    q = q / TICK_MS;
    if (q > 32'hFFFF) return 16'hFFFF;
    return q[TICKS_W-1:0];
  endfunction

  // Places the task after every entry that expires no later than it does.
  function automatic void queue_insert(input logic [TASK_W-1:0] id,
                                       input logic [TICKS_W-1:0] delay,
                                       input logic [TICKS_W-1:0] period);
    int unsigned pos;
    logic [TICKS_W-1:0] rest;
    pos = 0;
    rest = delay;
    while (pos < q_len && rest >= q_delta[pos]) begin
      rest = rest - q_delta[pos];
      pos++;
    end
    if (pos < q_len) q_delta[pos] = q_delta[pos] - rest;
    for (int unsigned i = q_len; i > pos; i--) begin
      q_task[i]   = q_task[i-1];
      q_delta[i]  = q_delta[i-1];
      q_period[i] = q_period[i-1];
    end
    q_task[pos]   = id;
    q_delta[pos]  = rest;
    q_period[pos] = period;
    q_len++;
  endfunction

  function automatic void queue_remove(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_len; i++) begin
      q_task[i]   = q_task[i+1];
      q_delta[i]  = q_delta[i+1];
      q_period[i] = q_period[i+1];
    end
    q_len--;
  endfunction

  function automatic dltq_rsp_t apply_command(input dltq_req_t r);
    dltq_rsp_t o;
    logic [TASK_W-1:0] t;
    logic [TICKS_W-1:0] p;
    int unsigned i;
    int unsigned s;
    o = '0;
    case (r.command)
      CMD_ADD: begin
        if (q_len >= MAX_TASKS) o.status = 1'b1;
        else queue_insert(r.task_id, ms_to_ticks(r.delay_ms), ms_to_ticks(r.period_ms));
      end
      CMD_TICK: begin
        if (q_len > 0 && q_delta[0] > 0) q_delta[0] = q_delta[0] - 16'd1;
      end
      CMD_DISPATCH: begin
        if (q_len > 0 && q_delta[0] == 0) begin
          t = q_task[0];
          p = q_period[0];
          o.fired = 1'b1;
          o.fired_task = t;
          queue_remove(0);
          if (p > 0) queue_insert(t, p, p);
        end
      end
      CMD_DELETE: begin
        i = 0;
        while (i < q_len) begin
          if (q_task[i] == r.task_id) begin
            // The removed delay moves onto the next entry so later expiries hold.
            if (i + 1 < q_len) begin
              s = q_delta[i+1] + q_delta[i];
              q_delta[i+1] = (s > 32'hFFFF) ? 16'hFFFF : s[TICKS_W-1:0];
            end
            queue_remove(i);
          end else begin
            i++;
          end
        end
      end
    endcase
    o.task_count = q_len[CNT_OUT_W-1:0];
    return o;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic dir_row_t dir_row(input logic [CMD_W-1:0] cmd,
                                       input logic [TASK_W-1:0] id,
                                       input logic [MS_W-1:0] dly,
                                       input logic [MS_W-1:0] per,
                                       input int reps, input int step_ms, input bit lit,
                                       input logic fired, input logic [TASK_W-1:0] ftask,
                                       input logic status, input logic [CNT_OUT_W-1:0] cnt);
    dir_row_t row;
    row.req.command   = cmd;
    row.req.task_id   = id;
    row.req.delay_ms  = dly;
    row.req.period_ms = per;
    row.reps          = reps;
    row.step_ms       = step_ms;
    row.lit           = lit;
    row.want.fired      = fired;
    row.want.fired_task = ftask;
    row.want.status     = status;
    row.want.task_count = cnt;
    return row;
  endfunction

  // Mostly a small id pool so deletes hit, with full-range ids now and then.
  function automatic dltq_req_t random_cmd();
    dltq_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.command = CMD_ADD;
    else if (pick < 65) r.command = CMD_TICK;
    else if (pick < 90) r.command = CMD_DISPATCH;
    else r.command = CMD_DELETE;
    r.task_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: r.delay_ms = 20'($urandom_range(0, 300));
      6, 7:             r.delay_ms = 20'($urandom_range(0, 5000));
      8:                r.delay_ms = 20'($urandom_range(0, 20'hFFFFF));
      default:          r.delay_ms = '0;
    endcase
    case ($urandom_range(0, 4))
      0, 1:    r.period_ms = '0;
      2, 3:    r.period_ms = 20'($urandom_range(10, 200));
      default: r.period_ms = 20'($urandom_range(0, 20'hFFFFF));
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input dltq_req_t r, input bit lit, input dltq_rsp_t want);
    dltq_rsp_t model;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    model = apply_command(r);
    awaited_rsp.push_back(lit ? want : model);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(negedge clk);
    while (awaited_rsp.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rsp_hold != 0) begin
      rsp_hold = rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (!quiet && !rst && $urandom_range(0, 11) == 0) begin
      rsp_hold = $urandom_range(0, 9);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_rsp
    dltq_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("result item with no command pending");
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        check_field("fired", want.fired, rsp.fired);
        check_field("fired_task", want.fired_task, rsp.fired_task);
        check_field("status", want.status, rsp.status);
        check_field("task_count", want.task_count, rsp.task_count);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_delta_list_task_timer_queue failed");
    $finish;
  end

  initial begin : stimulus
    dltq_req_t cur;
    dltq_rsp_t none;
    none      = '0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;

    // Empty queue first, then extremes, scaling, re-queue and a full queue.
    dir_rows.push_back(dir_row(CMD_TICK,     8'h00, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DELETE,   8'h5A, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_ADD,      8'hFF, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd1));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 1, 1, 8'hFF, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_ADD, 8'h00, 20'hFFFFF, 20'hFFFFF, 1, 0, 1, 0, 8'h00, 0, 5'd1));
    dir_rows.push_back(dir_row(CMD_ADD, 8'h01, 20'd655359, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd2));
    dir_rows.push_back(dir_row(CMD_ADD,      8'h02, 20'd9, 20'd25, 1, 0, 1, 0, 8'h00, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_TICK,     8'h00, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 1, 1, 8'h02, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_TICK,     8'h00, 20'd0, 20'd0, 2, 0, 1, 0, 8'h00, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 1, 1, 8'h02, 0, 5'd3));
    dir_rows.push_back(dir_row(CMD_DELETE,   8'h00, 20'd0, 20'd0, 1, 0, 1, 0, 8'h00, 0, 5'd2));
    dir_rows.push_back(dir_row(CMD_ADD,      8'hAA, 20'd0, 20'd40, 14, 130, 0, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_ADD,      8'h7E, 20'd5, 20'd0, 1, 0, 1, 0, 8'h00, 1, 5'd16));
    dir_rows.push_back(dir_row(CMD_TICK,     8'h00, 20'd0, 20'd0, 1, 0, 0, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DISPATCH, 8'h00, 20'd0, 20'd0, 1, 0, 0, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DELETE,   8'hAA, 20'd0, 20'd0, 1, 0, 0, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DELETE,   8'h01, 20'd0, 20'd0, 1, 0, 0, 0, 8'h00, 0, 5'd0));
    dir_rows.push_back(dir_row(CMD_DELETE,   8'h02, 20'd0, 20'd0, 1, 0, 0, 0, 8'h00, 0, 5'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[n]) begin
      for (int k = 0; k < dir_rows[n].reps; k++) begin
        cur = dir_rows[n].req;
        cur.delay_ms = cur.delay_ms + 20'(k * dir_rows[n].step_ms);
        send_req(cur, dir_rows[n].lit, dir_rows[n].want);
      end
    end
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= 250 && n < 290) || (n >= RAND_ITEMS - 60);
      if (n % 125 == 124) drain_results();
      send_req(random_cmd(), 1'b0, none);
    end

    req_valid <= 1'b0;
    @(negedge clk);
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (2 * MAX_TASKS + 8) @(negedge clk);

    if (errors == 0) begin
      $display("tb_delta_list_task_timer_queue passed");
    end else begin
      $display("tb_delta_list_task_timer_queue failed");
    end
    $finish;
  end

endmodule
